FILE: src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes of the first-fit block allocator
// Command and result transaction layouts, status and kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

    localparam int SIZE_W = 12;
    localparam int KEY_W  = 32;

    // Command kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_IGNORED  = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] alloc_size;
        logic [KEY_W-1:0]  ptr_key;
        logic [SIZE_W-1:0] block_offset;
    } in_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] result_offset;
        logic [1:0]        status;
    } out_item_t;

    // Header evaluation flags from the shared unit
    typedef struct packed {
        logic fit;     // free block usable for the request
        logic exact;   // size equals the request, no split
    } alu_flags_t;

endpackage

`default_nettype wire

FILE: src/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram: generic single-port RAM
// One read or write per cycle, registered read data, no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: src/ffba_alu.sv
// ----------------------------------------------------------------------------
// ffba_alu: shared header arithmetic unit
// Computes base + header + addend, the fit test and the split remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffba_alu #(
    parameter int HEADER_SIZE = 16,
    parameter int CW          = 14
) (
    input  wire logic [CW-1:0]               base,
    input  wire logic [ffba_pkg::SIZE_W-1:0] addend,
    input  wire logic [ffba_pkg::SIZE_W-1:0] blk_size,
    input  wire logic                        blk_used,
    input  wire logic [ffba_pkg::SIZE_W-1:0] req,
    output logic      [CW-1:0]               sum,
    output logic      [ffba_pkg::SIZE_W-1:0] remainder,
    output ffba_pkg::alu_flags_t             flags
);

    import ffba_pkg::*;

    localparam logic [CW-1:0] HS_C = CW'(HEADER_SIZE);

    logic [CW-1:0] req_hs;
    logic [CW-1:0] rem_wide;

    // Next position / frontier
    assign sum = base + HS_C + CW'(addend);

    // Fit test: block not in use, and exact size or room for the request plus a new header
    assign req_hs      = CW'(req) + HS_C;
    assign flags.exact = (blk_size == req);
    assign flags.fit   = !blk_used && (flags.exact || (CW'(blk_size) >= req_hs));

    // Size of the free block left after a split
    assign rem_wide  = CW'(blk_size) - req_hs;
    assign remainder = rem_wide[SIZE_W-1:0];

endmodule

`default_nettype wire

FILE: src/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit heap allocator with block headers
// Walks headers from offset 0 to the frontier, splits or appends on allocate,
// clears the in-use mark on free.
// ----------------------------------------------------------------------------
// Allocate: each header visited is a RAM read (issue) then an evaluate in the shared
//   unit, then headers are written (split if needed, then take); strobe follows the last step.
// Free: applied through the free state, or reported as ignored from idle. One command at a time.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears the frontier, heap key and sequencer; header RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
    parameter int HEAP_SIZE   = 4096,
    parameter int HEADER_SIZE = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire ffba_pkg::in_item_t         cmd,
    output logic                            result_valid,
    output ffba_pkg::out_item_t             result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [ffba_pkg::KEY_W-1:0] cfg_data
);

    import ffba_pkg::*;

    localparam int AW = $clog2(HEAP_SIZE);
    localparam int PW = AW + 1;
    localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
    localparam logic [CW-1:0] HEAP_C = CW'(HEAP_SIZE);
    localparam logic [CW-1:0] HS_C   = CW'(HEADER_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_EVAL,
        S_SPLIT,
        S_TAKE,
        S_FREE
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [AW-1:0]     take_pos_reg, take_pos_next;
    logic [CW-1:0]     split_pos_reg, split_pos_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic              append_reg, append_next;
    logic [PW-1:0]     frontier_reg, frontier_next;
    logic [PW-1:0]     front_new_reg, front_new_next;
    logic [AW-1:0]     free_addr_reg, free_addr_next;
    logic              result_valid_reg, result_valid_next;
    out_item_t         result_reg, result_next;
    logic [KEY_W-1:0]  heap_key_reg;

    logic [CW-1:0]     alu_base;
    logic [SIZE_W-1:0] alu_addend;
    logic [CW-1:0]     alu_sum;
    logic [SIZE_W-1:0] alu_rem;
    alu_flags_t        alu_flags;

    logic [AW-1:0]     ram_addr;
    logic              size_we;
    logic              used_we;
    logic [SIZE_W-1:0] size_wdata;
    logic              used_wdata;
    logic [SIZE_W-1:0] rd_size;
    logic              rd_used;

    logic              walk_more;
    logic              append_ok;
    logic [CW-1:0]     front_hs;
    logic [CW-1:0]     off_c;
    logic [CW-1:0]     free_pos;
    logic              free_ok;
    logic              split_ok;
    logic [CW-1:0]     payload;

    // Configuration: heap key; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            heap_key_reg <= cfg_data;
        end
    end

    // Header store: payload size and in-use mark per byte offset
    ffba_ram #(.WIDTH(SIZE_W), .DEPTH(HEAP_SIZE)) u_size_ram (
        .clk   (clk),
        .we    (size_we),
        .addr  (ram_addr),
        .wdata (size_wdata),
        .rdata (rd_size)
    );

    ffba_ram #(.WIDTH(1), .DEPTH(HEAP_SIZE)) u_used_ram (
        .clk   (clk),
        .we    (used_we),
        .addr  (ram_addr),
        .wdata (used_wdata),
        .rdata (rd_used)
    );

    // Shared arithmetic unit: frontier check on issue, header step on evaluate
    assign alu_base   = (state_reg == S_ISSUE) ? CW'(frontier_reg) : pos_reg;
    assign alu_addend = ((state_reg == S_EVAL) && !alu_flags.fit) ? rd_size : req_reg;

    ffba_alu #(.HEADER_SIZE(HEADER_SIZE), .CW(CW)) u_alu (
        .base      (alu_base),
        .addend    (alu_addend),
        .blk_size  (rd_size),
        .blk_used  (rd_used),
        .req       (req_reg),
        .sum       (alu_sum),
        .remainder (alu_rem),
        .flags     (alu_flags)
    );

    // Walk and append conditions
    assign walk_more = (pos_reg < CW'(frontier_reg)) && (pos_reg < HEAP_C);
    assign front_hs  = CW'(frontier_reg) + HS_C;
    assign append_ok = (alu_sum <= HEAP_C) && (front_hs < HEAP_C);
    assign split_ok  = (split_pos_reg < HEAP_C);
    assign payload   = CW'(take_pos_reg) + HS_C;

    // Free checks: null pointer, foreign key, offset range
    assign off_c    = CW'(cmd.block_offset);
    assign free_pos = off_c - HS_C;
    assign free_ok  = !((cmd.ptr_key == '0) && (cmd.block_offset == '0))
                   && (cmd.ptr_key == heap_key_reg)
                   && (off_c >= HS_C)
                   && (free_pos < HEAP_C);

    // RAM port steering
    always_comb
    begin
        unique case (state_reg)
            S_SPLIT: ram_addr = split_pos_reg[AW-1:0];
            S_TAKE:  ram_addr = take_pos_reg;
            S_FREE:  ram_addr = free_addr_reg;
            default: ram_addr = pos_reg[AW-1:0];
        endcase
    end

    assign size_we    = ((state_reg == S_SPLIT) && split_ok) || (state_reg == S_TAKE);
    assign used_we    = size_we || (state_reg == S_FREE);
    assign size_wdata = (state_reg == S_SPLIT) ? rem_reg : req_reg;
    assign used_wdata = (state_reg == S_TAKE);

    // Sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        pos_next          = pos_reg;
        req_next          = req_reg;
        take_pos_next     = take_pos_reg;
        split_pos_next    = split_pos_reg;
        rem_next          = rem_reg;
        append_next       = append_reg;
        frontier_next     = frontier_reg;
        front_new_next    = front_new_reg;
        free_addr_next    = free_addr_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.kind == KIND_ALLOC)
                    begin
                        pos_next   = '0;
                        req_next   = cmd.alloc_size;
                        state_next = S_ISSUE;
                    end
                    else if (free_ok)
                    begin
                        free_addr_next = free_pos[AW-1:0];
                        state_next     = S_FREE;
                    end
                    else
                    begin
                        result_valid_next         = 1'b1;
                        result_next.result_offset = '0;
                        result_next.status        = STATUS_IGNORED;
                    end
                end
            end

            // Read header at pos, or decide on an append, or report no space
            S_ISSUE:
            begin
                if (walk_more)
                begin
                    state_next = S_EVAL;
                end
                else if (append_ok)
                begin
                    take_pos_next  = frontier_reg[AW-1:0];
                    append_next    = 1'b1;
                    front_new_next = alu_sum[PW-1:0];
                    state_next     = S_TAKE;
                end
                else
                begin
                    result_valid_next         = 1'b1;
                    result_next.result_offset = '0;
                    result_next.status        = STATUS_NO_SPACE;
                    state_next                = S_IDLE;
                end
            end

            // Header data is back: take, split or step on
            S_EVAL:
            begin
                if (alu_flags.fit)
                begin
                    take_pos_next = pos_reg[AW-1:0];
                    append_next   = 1'b0;
                    if (alu_flags.exact)
                    begin
                        state_next = S_TAKE;
                    end
                    else
                    begin
                        split_pos_next = alu_sum;
                        rem_next       = alu_rem;
                        state_next     = S_SPLIT;
                    end
                end
                else
                begin
                    pos_next   = alu_sum;
                    state_next = S_ISSUE;
                end
            end

            S_SPLIT:
            begin
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                if (append_reg)
                begin
                    frontier_next = front_new_reg;
                end
                result_valid_next         = 1'b1;
                result_next.result_offset = payload[SIZE_W-1:0];
                result_next.status        = STATUS_OK;
                state_next                = S_IDLE;
            end

            S_FREE:
            begin
                result_valid_next         = 1'b1;
                result_next.result_offset = '0;
                result_next.status        = STATUS_OK;
                state_next                = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            frontier_reg     <= '0;
            result_valid_reg <= 1'b0;
            append_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            frontier_reg     <= frontier_next;
            result_valid_reg <= result_valid_next;
            append_reg       <= append_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        req_reg       <= req_next;
        take_pos_reg  <= take_pos_next;
        split_pos_reg <= split_pos_next;
        rem_reg       <= rem_next;
        front_new_reg <= front_new_next;
        free_addr_reg <= free_addr_next;
        result_reg    <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // Result strobe only while the sequencer is back at idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted command either starts work or reports at once
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_valid))
        else $error("accepted command was dropped");

    // Frontier never passes the end of the heap
    a_frontier_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(frontier_reg) <= HEAP_C)
        else $error("frontier beyond heap end");

    // Frontier moves only together with a successful result
    a_frontier_move: assert property (@(posedge clk) disable iff (!rst_n)
        (frontier_reg != $past(frontier_reg))
            |-> (result_valid && (result.status == STATUS_OK)))
        else $error("frontier moved without a successful allocation");

    // No undefined status code is ever reported
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK || result.status == STATUS_NO_SPACE
                          || result.status == STATUS_IGNORED))
        else $error("bad status code");
`endif

endmodule

`default_nettype wire
